@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle
`define CHK_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication in the following cycle
`define CHK_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/llba_pkg.sv @@
`timescale 1ns / 1ps

package llba_pkg;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned WEIGHT_W   = 16;
  localparam int unsigned BIN_NUM_W  = 7;
  localparam int unsigned LOAD_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_BINS     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD_LIMIT = 4'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_SPAN
  } state_t;

endpackage

@@ rtl/least_loaded_bin_assigner_core.sv @@
`timescale 1ns / 1ps

// Least-loaded bin assigner. Each item carries a weight and a batch_end flag and
// is taken on a clock edge with start high and busy low. The block reads the
// loads of bins 1..n (n from num_bins, 0 taken as 1, capped at NUM_BINS_MAX) out
// of a one-port-read, one-port-write load memory, one per cycle, picks the
// smallest (lowest number on a tie), adds the weight with saturation and writes
// it back. One result word per item: done pulses for one cycle with bin_number,
// batch_done and balanced; the receiver cannot stall it.
// For an ordinary item the block scans the n loads, writes the new load back
// and then pulses done; busy is low again in that same cycle, and the next word
// is taken only after that, so the read loop sets how long each item takes.
// On a batch_end item the block reads all n loads a second time for the min/max
// spread, then pulses done and sweeps zeros through all NUM_BINS_MAX entries,
// one per cycle, staying busy meanwhile.
// Reset (rst, synchronous) loads num_bins = 1, spread_limit = 0 and runs the same
// clearing sweep over all NUM_BINS_MAX entries before the first item is taken.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are taken at
// any time; unknown indexes are ignored. Write them only while idle.
module least_loaded_bin_assigner_core #(
  parameter int unsigned NUM_BINS_MAX = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [llba_pkg::WEIGHT_W-1:0]        weight,
  input  logic                                 batch_end,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [llba_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [llba_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 done,
  output logic [llba_pkg::BIN_NUM_W-1:0]       bin_number,
  output logic                                 batch_done,
  output logic                                 balanced
);

  localparam int unsigned IDXW = (NUM_BINS_MAX > 1) ? $clog2(NUM_BINS_MAX) : 1;
  localparam int unsigned CNTW = $clog2(NUM_BINS_MAX + 1);
  localparam int unsigned LW   = llba_pkg::LOAD_W;

  llba_pkg::state_t state, state_next;

  logic [LW-1:0]   load_mem [NUM_BINS_MAX];
  logic [LW-1:0]   rd_data;
  logic            mem_we;
  logic [IDXW-1:0] mem_waddr;
  logic [LW-1:0]   mem_wdata;
  logic [IDXW-1:0] mem_raddr;

  logic [llba_pkg::BIN_NUM_W-1:0]  num_bins;
  logic [llba_pkg::WEIGHT_W-1:0]   spread_limit;

  logic [llba_pkg::WEIGHT_W-1:0]   item_weight;
  logic                            item_last;
  logic [CNTW-1:0]                 cnt;
  logic [CNTW-1:0]                 cnt_next;
  logic [CNTW-1:0]                 iss;
  logic                            rv;
  logic [IDXW-1:0]                 ridx;
  logic [IDXW-1:0]                 clr;
  logic [IDXW-1:0]                 best;
  logic [LW-1:0]                   best_load;
  logic [LW-1:0]                   lo;
  logic [LW-1:0]                   hi;
  logic [LW:0]                     sum;
  logic [LW-1:0]                   sat_load;
  logic                            accept;
  logic                            scanning;
  logic                            issue;
  logic                            scan_end;

  assign cfg_ready = 1'b1;
  assign busy      = (state != llba_pkg::ST_IDLE);
  assign accept    = start && !busy;

  // effective bin count: zero acts as one, capped at the memory depth
  always_comb begin
    if (num_bins == '0) begin
      cnt_next = CNTW'(1);
    end else if (32'(num_bins) > 32'(NUM_BINS_MAX)) begin
      cnt_next = CNTW'(NUM_BINS_MAX);
    end else begin
      cnt_next = CNTW'(num_bins);
    end
  end

  assign scanning  = (state == llba_pkg::ST_SCAN) || (state == llba_pkg::ST_SPAN);
  assign issue     = scanning && (iss < cnt);
  assign scan_end  = scanning && !issue && !rv;
  assign mem_raddr = iss[IDXW-1:0];

  assign sum      = {1'b0, best_load} + (LW + 1)'(item_weight);
  assign sat_load = sum[LW] ? '1 : sum[LW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= llba_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = clr;
    mem_wdata  = '0;
    unique case (state)
      llba_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr == IDXW'(NUM_BINS_MAX - 1)) begin
          state_next = llba_pkg::ST_IDLE;
        end
      end
      llba_pkg::ST_IDLE: begin
        if (start) begin
          state_next = llba_pkg::ST_SCAN;
        end
      end
      llba_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_next = llba_pkg::ST_WRITE;
        end
      end
      llba_pkg::ST_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = best;
        mem_wdata = sat_load;
        state_next = item_last ? llba_pkg::ST_SPAN : llba_pkg::ST_IDLE;
      end
      llba_pkg::ST_SPAN: begin
        if (scan_end) begin
          state_next = llba_pkg::ST_CLEAR;
        end
      end
      default: begin
        state_next = llba_pkg::ST_CLEAR;
      end
    endcase
  end

  // load memory, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) begin
      load_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= load_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_bins     <= llba_pkg::BIN_NUM_W'(1);
      spread_limit <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == llba_pkg::REG_NUM_BINS) begin
        num_bins <= cfg_data[llba_pkg::BIN_NUM_W-1:0];
      end else if (cfg_index == llba_pkg::REG_SPREAD_LIMIT) begin
        spread_limit <= cfg_data[llba_pkg::WEIGHT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr  <= '0;
      iss  <= '0;
      rv   <= 1'b0;
      done <= 1'b0;
    end else begin
      clr  <= (state == llba_pkg::ST_CLEAR) ? clr + 1'b1 : '0;
      iss  <= issue ? iss + 1'b1 : (scanning ? iss : '0);
      rv   <= issue;
      done <= ((state == llba_pkg::ST_WRITE) && !item_last) ||
              ((state == llba_pkg::ST_SPAN) && scan_end);
    end
  end

  always_ff @(posedge clk) begin
    ridx <= mem_raddr;
    if (accept) begin
      item_weight <= weight;
      item_last   <= batch_end;
      cnt         <= cnt_next;
    end
    if ((state == llba_pkg::ST_SCAN) && rv) begin
      // strict less keeps the lowest bin number on a tie
      if ((ridx == '0) || (rd_data < best_load)) begin
        best      <= ridx;
        best_load <= rd_data;
      end
    end
    if ((state == llba_pkg::ST_SPAN) && rv) begin
      if (ridx == '0) begin
        lo <= rd_data;
        hi <= rd_data;
      end else begin
        if (rd_data < lo) begin
          lo <= rd_data;
        end
        if (rd_data > hi) begin
          hi <= rd_data;
        end
      end
    end
    if (state == llba_pkg::ST_WRITE) begin
      bin_number <= llba_pkg::BIN_NUM_W'(32'(best) + 32'd1);
      batch_done <= item_last;
      balanced   <= 1'b0;
    end else if ((state == llba_pkg::ST_SPAN) && scan_end) begin
      balanced <= ((hi - lo) <= LW'(spread_limit));
    end
  end

endmodule

@@ rtl/llba_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module llba_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic [llba_pkg::BIN_NUM_W-1:0]    bin_number,
  input logic                              batch_done,
  input logic                              balanced
);

  // a taken word makes the block busy and no result shows in the next cycle
  `CHK_NEXT(a_take_busy, clk, rst, start && !busy, busy && !done)

  // results come only out of a busy cycle
  `CHK_NEXT(a_done_src, clk, rst, !busy, !done)

  // bins are numbered from one
  `CHK_SAME(a_bin_nonzero, clk, rst, done, bin_number != '0)

  // balanced means nothing outside a batch end
  `CHK_SAME(a_bal_batch, clk, rst, done && !batch_done, !balanced)

endmodule

bind least_loaded_bin_assigner_core llba_checker u_llba_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .bin_number (bin_number),
  .batch_done (batch_done),
  .balanced   (balanced)
);
